### src/tcce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types, codes and helpers for the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // Default number of spaces a tab expands to
  localparam int TAB_SPACES_DEF = 4;

  // Most commands a single input transaction may produce
  localparam int MAX_RESULTS = 8;

  // Drawing command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_DRAW   = 2'd1;
  localparam logic [1:0] CMD_SCROLL = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_SCROLL  = 2'd2;

  // Register reset values
  localparam logic [7:0] COLUMNS_RST = 8'd80;
  localparam logic [7:0] ROWS_RST    = 8'd30;
  localparam logic [7:0] SCROLL_RST  = 8'd1;

  // Character codes with special meaning
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_CR        = 8'd13;
  localparam logic [7:0] CH_ESC       = 8'd27;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // Colour used for a zero colour index and for tab spaces
  localparam logic [3:0] COLOUR_WHITE = 4'hF;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the incoming transaction
    logic do_bs;      // issue the backspace clear and move back
    logic do_scroll;  // issue a scroll and move the row up
    logic do_draw;    // draw a glyph (or take a newline) and advance
  } tcce_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_ignored;    // incoming character produces nothing
    logic in_backspace;  // incoming character is a backspace
    logic can_emit;      // output register can take a command this cycle
    logic place_done;    // no further placement for this transaction
    logic need_scroll;   // cursor row is at or past the row count
    logic is_newline;    // captured character is a newline
  } tcce_status_t;

  // Row increment that holds at the top of the 8-bit range
  function automatic logic [7:0] sat_inc(input logic [7:0] val);
    return (val == 8'hFF) ? val : val + 8'd1;
  endfunction

endpackage

### src/text_console_cursor_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Turns a character stream into clear, draw and scroll cell commands while
// tracking a text cursor.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  char_code, target_row/col, colour
//   out_     output     out_valid/out_stall command, cell, glyph, scroll, last
//   cfg_     input      cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// Steps: CR and ESC are taken and produce no command. A backspace issues one
// clear; a glyph or a newline passes a row check and a draw, and a tab does so
// for each of up to TAB_SPACES spaces. A scroll, when the row needs it, goes
// out in the row-check state that precedes a draw. The sequencer issues at most
// one command per cycle into the single output register.
// Reset: synchronous, active low; cursor at 0,0, registers at 80/30/1.
// Stalls: out_stall holds the output register and the sequencer waits;
// in_stall stays high until every command of the transaction is issued.
//
// The block accepts the next transaction while the last command of the
// previous one still waits in the output register.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit #(
  parameter int TAB_SPACES = tcce_pkg::TAB_SPACES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  // input transactions
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_char_code,
  input  logic signed [8:0] in_target_row,
  input  logic signed [8:0] in_target_col,
  input  logic [3:0]        in_colour,
  // result transactions
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_command,
  output logic [7:0]        out_cell_row,
  output logic [7:0]        out_cell_col,
  output logic [7:0]        out_glyph_code,
  output logic [3:0]        out_glyph_colour,
  output logic [7:0]        out_scroll_lines,
  output logic              out_last_of_run
);
  import tcce_pkg::*;

  // command and status between sequencer and datapath
  tcce_cmd_t    cmd;
  tcce_status_t status;

  // sequencer: capture, backspace, then scroll-check / draw per placement
  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // cursor arithmetic, configuration and the output register
  tcce_datapath #(
    .TAB_SPACES (TAB_SPACES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_char_code     (in_char_code),
    .in_target_row    (in_target_row),
    .in_target_col    (in_target_col),
    .in_colour        (in_colour),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command      (out_command),
    .out_cell_row     (out_cell_row),
    .out_cell_col     (out_cell_col),
    .out_glyph_code   (out_glyph_code),
    .out_glyph_colour (out_glyph_colour),
    .out_scroll_lines (out_scroll_lines),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

### src/tcce_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_ctrl
// Sequencer that walks one input transaction through its cell commands.
// ----------------------------------------------------------------------------
module tcce_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tcce_pkg::tcce_status_t status,
  output tcce_pkg::tcce_cmd_t    cmd
);
  import tcce_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_BS    = 2'd1;
  localparam logic [1:0] S_PLACE = 2'd2;
  localparam logic [1:0] S_DRAW  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !status.in_ignored) begin
          cmd.load  = 1'b1;
          state_nxt = status.in_backspace ? S_BS : S_PLACE;
        end
      end
      S_BS: begin
        if (status.can_emit) begin
          cmd.do_bs = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_PLACE: begin
        if (status.place_done) begin
          state_nxt = S_IDLE;
        end else if (!status.need_scroll) begin
          state_nxt = S_DRAW;
        end else if (status.can_emit) begin
          cmd.do_scroll = 1'b1;
          state_nxt     = S_DRAW;
        end
      end
      S_DRAW: begin
        // newline moves the cursor without a command
        if (status.is_newline || status.can_emit) begin
          cmd.do_draw = 1'b1;
          state_nxt   = S_PLACE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/tcce_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_datapath
// Cursor, configuration and output registers with the placement arithmetic.
// ----------------------------------------------------------------------------
module tcce_datapath #(
  parameter int TAB_SPACES = tcce_pkg::TAB_SPACES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [1:0]             cfg_index,
  input  logic [7:0]             cfg_wdata,
  input  logic [7:0]             in_char_code,
  input  logic signed [8:0]      in_target_row,
  input  logic signed [8:0]      in_target_col,
  input  logic [3:0]             in_colour,
  input  tcce_pkg::tcce_cmd_t    cmd,
  output tcce_pkg::tcce_status_t status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_command,
  output logic [7:0]             out_cell_row,
  output logic [7:0]             out_cell_col,
  output logic [7:0]             out_glyph_code,
  output logic [3:0]             out_glyph_colour,
  output logic [7:0]             out_scroll_lines,
  output logic                   out_last_of_run
);
  import tcce_pkg::*;

  localparam int RemW = $clog2(TAB_SPACES + 1);
  localparam int CntW = $clog2(MAX_RESULTS + 4);

  // configuration
  logic [7:0] columns_r, rows_r, scroll_amt_r;

  // cursor and per-transaction context
  logic [7:0]      cur_col_r, cur_row_r;
  logic [7:0]      ch_r;
  logic [3:0]      colour_r;
  logic            is_tab_r;
  logic [RemW-1:0] rem_r;
  logic [CntW-1:0] cnt_r;

  // output register
  logic       out_valid_r;
  logic [1:0] out_command_r;
  logic [7:0] out_cell_row_r, out_cell_col_r, out_glyph_code_r, out_scroll_lines_r;
  logic [3:0] out_glyph_colour_r;
  logic       out_last_r;

  // incoming decode
  logic       in_is_tab;
  logic       in_explicit;
  logic [3:0] in_colour_fix;

  assign in_is_tab     = (in_char_code == CH_TAB);
  assign in_explicit   = !in_target_row[8] && !in_target_col[8];
  assign in_colour_fix = (in_colour == 4'd0) ? COLOUR_WHITE : in_colour;

  // backspace target
  logic [7:0] bs_col, bs_row;
  always_comb begin
    bs_col = cur_col_r - 8'd1;
    bs_row = cur_row_r;
    if (cur_col_r == 8'd0) begin
      bs_col = (columns_r != 8'd0) ? columns_r - 8'd1 : 8'd0;
      if (cur_row_r == 8'd0) begin
        bs_col = 8'd0;
      end else begin
        bs_row = cur_row_r - 8'd1;
      end
    end
  end

  // scroll target row, floored at zero
  logic [7:0] scr_row;
  assign scr_row = (cur_row_r >= scroll_amt_r) ? cur_row_r - scroll_amt_r : 8'd0;

  // draw or newline step with line wrap
  logic       is_nl;
  logic [7:0] row_a;
  logic [8:0] col_a;
  logic       wrap;
  logic [7:0] draw_col, draw_row;
  assign is_nl    = (ch_r == CH_NEWLINE);
  assign row_a    = is_nl ? sat_inc(cur_row_r) : cur_row_r;
  assign col_a    = is_nl ? 9'd0 : {1'b0, cur_col_r} + 9'd1;
  assign wrap     = (col_a >= {1'b0, columns_r});
  assign draw_col = wrap ? 8'd0 : col_a[7:0];
  assign draw_row = wrap ? sat_inc(row_a) : row_a;

  // lookahead: is the glyph being drawn the final command of this transaction
  logic [RemW-1:0] rem_dec;
  logic [CntW-1:0] need_now, need_next;
  logic            draw_last;
  assign rem_dec   = rem_r - RemW'(1);
  assign need_now  = (cur_row_r >= rows_r) ? CntW'(2) : CntW'(1);
  assign need_next = (draw_row >= rows_r) ? CntW'(2) : CntW'(1);
  assign draw_last = (rem_dec == '0) ||
                     ((cnt_r + CntW'(1) + need_next) > CntW'(MAX_RESULTS));

  logic emit;
  assign emit = cmd.do_bs || cmd.do_scroll || (cmd.do_draw && !is_nl);

  always_comb begin
    status              = '0;
    status.in_ignored   = (in_char_code == CH_CR) || (in_char_code == CH_ESC);
    status.in_backspace = (in_char_code == CH_BACKSPACE);
    status.can_emit     = !out_valid_r || !out_stall;
    status.place_done   = (rem_r == '0) ||
                          ((cnt_r + need_now) > CntW'(MAX_RESULTS));
    status.need_scroll  = (cur_row_r >= rows_r);
    status.is_newline   = is_nl;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r    <= COLUMNS_RST;
      rows_r       <= ROWS_RST;
      scroll_amt_r <= SCROLL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COLUMNS: columns_r    <= cfg_wdata;
        REG_ROWS:    rows_r       <= cfg_wdata;
        REG_SCROLL:  scroll_amt_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // cursor and context
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= 8'd0;
      cur_row_r <= 8'd0;
      rem_r     <= '0;
      cnt_r     <= '0;
      is_tab_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        is_tab_r <= in_is_tab;
        ch_r     <= in_is_tab ? CH_SPACE : in_char_code;
        colour_r <= in_is_tab ? COLOUR_WHITE : in_colour_fix;
        rem_r    <= in_is_tab ? RemW'(TAB_SPACES) : RemW'(1);
        cnt_r    <= '0;
        if (!in_is_tab && in_explicit) begin
          cur_col_r <= in_target_col[7:0];
          cur_row_r <= in_target_row[7:0];
        end
      end
      if (cmd.do_bs) begin
        cur_col_r <= bs_col;
        cur_row_r <= bs_row;
      end
      if (cmd.do_scroll) begin
        cur_row_r <= scr_row;
        cnt_r     <= cnt_r + CntW'(1);
      end
      if (cmd.do_draw) begin
        cur_col_r <= draw_col;
        cur_row_r <= draw_row;
        rem_r     <= rem_dec;
        if (!is_nl) begin
          cnt_r <= cnt_r + CntW'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_bs) begin
      out_command_r      <= CMD_CLEAR;
      out_cell_row_r     <= bs_row;
      out_cell_col_r     <= bs_col;
      out_glyph_code_r   <= 8'd0;
      out_glyph_colour_r <= 4'd0;
      out_scroll_lines_r <= 8'd0;
      out_last_r         <= 1'b1;
    end else if (cmd.do_scroll) begin
      out_command_r      <= CMD_SCROLL;
      out_cell_row_r     <= 8'd0;
      out_cell_col_r     <= 8'd0;
      out_glyph_code_r   <= 8'd0;
      out_glyph_colour_r <= 4'd0;
      out_scroll_lines_r <= scroll_amt_r;
      out_last_r         <= is_nl;
    end else if (cmd.do_draw && !is_nl) begin
      out_command_r      <= CMD_DRAW;
      out_cell_row_r     <= cur_row_r;
      out_cell_col_r     <= cur_col_r;
      out_glyph_code_r   <= ch_r;
      out_glyph_colour_r <= colour_r;
      out_scroll_lines_r <= 8'd0;
      out_last_r         <= draw_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_command      = out_command_r;
  assign out_cell_row     = out_cell_row_r;
  assign out_cell_col     = out_cell_col_r;
  assign out_glyph_code   = out_glyph_code_r;
  assign out_glyph_colour = out_glyph_colour_r;
  assign out_scroll_lines = out_scroll_lines_r;
  assign out_last_of_run  = out_last_r;

`ifndef SYNTHESIS
  // a new command never lands on a result still held by the consumer
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || !out_stall))
    else $error("command issued over a stalled result");

  // command count stays within the per-transaction limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MAX_RESULTS))
    else $error("command count exceeds limit");

  // a non-tab transaction has a single placement left to count down
  a_tab_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_draw && !is_tab_r) |=> (rem_r == '0))
    else $error("non-tab transaction left placements pending");

  // a scroll command is only issued once the row reached the row count
  a_scroll_cause: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_scroll |-> (cur_row_r >= rows_r))
    else $error("scroll issued with row inside the window");
`endif

endmodule

### tb/tcce_cmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_cmd_checker
// Watches the configuration port and both channels of the cursor engine,
// keeps its own copy of the cursor and window geometry, predicts the cell
// commands of every accepted transaction and compares each accepted command
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tcce_cmd_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_char_code,
  input  logic signed [8:0] in_target_row,
  input  logic signed [8:0] in_target_col,
  input  logic [3:0]        in_colour,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_command,
  input  logic [7:0]        out_cell_row,
  input  logic [7:0]        out_cell_col,
  input  logic [7:0]        out_glyph_code,
  input  logic [3:0]        out_glyph_colour,
  input  logic [7:0]        out_scroll_lines,
  input  logic              out_last_of_run,
  output int                error_count,
  output int                pending_count
);
  import tcce_pkg::*;

  localparam int TAB_SPACES = TAB_SPACES_DEF;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] cell_row;
    logic [7:0] cell_col;
    logic [7:0] glyph_code;
    logic [3:0] glyph_colour;
    logic [7:0] scroll_lines;
    logic       last_of_run;
  } cell_cmd_t;

  logic [7:0] columns_q;
  logic [7:0] rows_q;
  logic [7:0] scroll_q;
  logic [7:0] cursor_col;
  logic [7:0] cursor_row;

  // working position while one transaction is expanded
  int         walk_col;
  int         walk_row;
  cell_cmd_t  run_buf [MAX_RESULTS];
  int         run_len;
  cell_cmd_t  expected_cmds [$];

  function automatic void add_cmd(input logic [1:0] cmd, input int row, input int col,
                                  input logic [7:0] glyph, input logic [3:0] ink,
                                  input logic [7:0] scroll);
    cell_cmd_t c;
    if (run_len >= MAX_RESULTS) return;
    c.command      = cmd;
    c.cell_row     = 8'(row);
    c.cell_col     = 8'(col);
    c.glyph_code   = glyph;
    c.glyph_colour = ink;
    c.scroll_lines = scroll;
    c.last_of_run  = 1'b0;
    run_buf[run_len] = c;
    run_len++;
  endfunction

  function automatic int bump_row(input int row);
    return (row >= 255) ? 255 : row + 1;
  endfunction

  // Scroll if needed, then draw or take the newline, then wrap.
  function automatic void place_glyph(input logic [7:0] ch, input logic [3:0] ink);
    if (walk_row >= int'(rows_q)) begin
      add_cmd(CMD_SCROLL, 0, 0, 8'd0, 4'd0, scroll_q);
      walk_row = (walk_row >= int'(scroll_q)) ? walk_row - int'(scroll_q) : 0;
    end
    if (ch == CH_NEWLINE) begin
      walk_col = 0;
      walk_row = bump_row(walk_row);
    end else begin
      add_cmd(CMD_DRAW, walk_row, walk_col, ch, ink, 8'd0);
      walk_col++;
    end
    if (walk_col >= int'(columns_q)) begin
      walk_col = 0;
      walk_row = bump_row(walk_row);
    end
  endfunction

  function automatic void predict_commands(input logic [7:0] ch,
                                           input logic signed [8:0] trow,
                                           input logic signed [8:0] tcol,
                                           input logic [3:0] colour);
    logic [3:0] ink;
    int         spaces;
    run_len = 0;
    if (ch == CH_ESC || ch == CH_CR) return;
    ink = (colour == 4'd0) ? COLOUR_WHITE : colour;

    if (ch == CH_TAB) begin
      walk_col = int'(cursor_col);
      walk_row = int'(cursor_row);
      spaces   = 0;
      while (spaces < TAB_SPACES &&
             run_len + ((walk_row >= int'(rows_q)) ? 2 : 1) <= MAX_RESULTS) begin
        place_glyph(CH_SPACE, COLOUR_WHITE);
        spaces++;
      end
    end else begin
      if (!trow[8] && !tcol[8]) begin
        walk_col = int'(tcol[7:0]);
        walk_row = int'(trow[7:0]);
      end else begin
        walk_col = int'(cursor_col);
        walk_row = int'(cursor_row);
      end
      if (ch == CH_BACKSPACE) begin
        if (walk_col == 0) begin
          walk_col = (columns_q > 0) ? int'(columns_q) - 1 : 0;
          if (walk_row == 0) walk_col = 0;
          else               walk_row--;
        end else begin
          walk_col--;
        end
        add_cmd(CMD_CLEAR, walk_row, walk_col, 8'd0, 4'd0, 8'd0);
      end else begin
        place_glyph(ch, ink);
      end
    end

    cursor_col = 8'(walk_col);
    cursor_row = (walk_row > 255) ? 8'hFF : 8'(walk_row);
    for (int i = 0; i < run_len; i++) begin
      run_buf[i].last_of_run = (i == run_len - 1);
      expected_cmds.push_back(run_buf[i]);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want_v,
                                      input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
      error_count++;
    end
  endfunction

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    cell_cmd_t want;
    cell_cmd_t got;
    if (!rst_n) begin
      columns_q  = COLUMNS_RST;
      rows_q     = ROWS_RST;
      scroll_q   = SCROLL_RST;
      cursor_col = 8'd0;
      cursor_row = 8'd0;
      expected_cmds.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_COLUMNS: columns_q = cfg_wdata;
          REG_ROWS:    rows_q    = cfg_wdata;
          REG_SCROLL:  scroll_q  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_commands(in_char_code, in_target_row, in_target_col, in_colour);
      if (out_valid && !out_stall) begin
        got = {out_command, out_cell_row, out_cell_col, out_glyph_code,
               out_glyph_colour, out_scroll_lines, out_last_of_run};
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected command: expected none, actual %h", $time, got);
          error_count++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("command",      want.command,      got.command);
          check_field("cell_row",     want.cell_row,     got.cell_row);
          check_field("cell_col",     want.cell_col,     got.cell_col);
          check_field("glyph_code",   want.glyph_code,   got.glyph_code);
          check_field("glyph_colour", want.glyph_colour, got.glyph_colour);
          check_field("scroll_lines", want.scroll_lines, got.scroll_lines);
          check_field("last_of_run",  want.last_of_run,  got.last_of_run);
        end
      end
    end
    pending_count = expected_cmds.size();
  end

endmodule

### tb/text_console_cursor_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit_tb
// Drives character transactions into the cursor engine under several window
// geometries and idle patterns; a separate checker predicts and compares the
// cell commands, and this top gives the verdict.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit_tb;
  import tcce_pkg::*;

  // negative target selects the cursor position
  localparam logic signed [8:0] AT_CURSOR = -9'sd1;
  // index that maps to no register
  localparam logic [1:0] REG_SPARE = 2'd3;
  // quiet cycles after the last command: covers a full tab plus scrolls
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 31;
  localparam int NUM_PHASES = 6;
  localparam int MAX_GAP = 30;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [1:0]        cfg_index;
  logic [7:0]        cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_char_code;
  logic signed [8:0] in_target_row;
  logic signed [8:0] in_target_col;
  logic [3:0]        in_colour;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_command;
  logic [7:0]        out_cell_row;
  logic [7:0]        out_cell_col;
  logic [7:0]        out_glyph_code;
  logic [3:0]        out_glyph_colour;
  logic [7:0]        out_scroll_lines;
  logic              out_last_of_run;

  int error_count;
  int pending_count;
  int send_idle_pct;
  int recv_stall_pct;
  // window geometry as last written, used to aim explicit cells
  int geo_cols;
  int geo_rows;

  text_console_cursor_engine_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_target_row    (in_target_row),
    .in_target_col    (in_target_col),
    .in_colour        (in_colour),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command      (out_command),
    .out_cell_row     (out_cell_row),
    .out_cell_col     (out_cell_col),
    .out_glyph_code   (out_glyph_code),
    .out_glyph_colour (out_glyph_colour),
    .out_scroll_lines (out_scroll_lines),
    .out_last_of_run  (out_last_of_run)
  );

  tcce_cmd_checker u_cmd_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_target_row    (in_target_row),
    .in_target_col    (in_target_col),
    .in_colour        (in_colour),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command      (out_command),
    .out_cell_row     (out_cell_row),
    .out_cell_col     (out_cell_col),
    .out_glyph_code   (out_glyph_code),
    .out_glyph_colour (out_glyph_colour),
    .out_scroll_lines (out_scroll_lines),
    .out_last_of_run  (out_last_of_run),
    .error_count      (error_count),
    .pending_count    (pending_count)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver back-pressure: redraw the stall at every falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 83; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 83; end
      default:       begin send_idle_pct = 38; recv_stall_pct = 38; end
    endcase
  endtask

  // Offer one transaction after a random idle gap and hold it until taken.
  task automatic send_char(input logic [7:0] ch, input logic signed [8:0] row,
                           input logic signed [8:0] col, input logic [3:0] colour);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    while (gap > 0) begin
      // drop valid and scramble the idle payload
      in_valid      <= 1'b0;
      in_char_code  <= 8'($urandom);
      in_target_row <= 9'($urandom);
      in_target_col <= 9'($urandom);
      in_colour     <= 4'($urandom);
      @(negedge clk);
      gap--;
    end
    in_valid      <= 1'b1;
    in_char_code  <= ch;
    in_target_row <= row;
    in_target_col <= col;
    in_colour     <= colour;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait for every predicted command, then let the block settle
  // (newlines and ignored characters may still be in flight).
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_geometry(input int cols, input int rws, input int scroll);
    drain_block();
    write_reg(REG_COLUMNS, 8'(cols));
    write_reg(REG_ROWS, 8'(rws));
    write_reg(REG_SCROLL, 8'(scroll));
    geo_cols = cols;
    geo_rows = rws;
  endtask

  // Mostly printable text at the cursor, with control characters, explicit
  // cells in and just past the window, far cells and half-negative targets.
  task automatic send_random_char();
    logic [7:0]        ch;
    logic signed [8:0] row;
    logic signed [8:0] col;
    int                pick;
    pick = $urandom_range(99);
    if (pick < 45)      ch = 8'($urandom_range(126, 32));
    else if (pick < 57) ch = CH_NEWLINE;
    else if (pick < 69) ch = CH_BACKSPACE;
    else if (pick < 77) ch = CH_TAB;
    else if (pick < 81) ch = pick[0] ? CH_CR : CH_ESC;
    else                ch = 8'($urandom_range(255));
    row  = AT_CURSOR;
    col  = AT_CURSOR;
    pick = $urandom_range(99);
    if (pick < 8) begin
      row = 9'($urandom_range(255));
      col = 9'($urandom_range(255));
    end else if (pick < 22) begin
      row = 9'($urandom_range(geo_rows));
      col = 9'($urandom_range(geo_cols));
    end else if (pick < 26) begin
      if (pick[0]) row = 9'($urandom_range(255));
      else         col = 9'($urandom_range(255));
    end
    send_char(ch, row, col, 4'($urandom_range(15)));
  endtask

  initial begin
    int phase;
    // hold every input at a known value and assert reset
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = REG_COLUMNS;
    cfg_wdata      = 8'd0;
    in_valid       = 1'b0;
    in_char_code   = 8'd0;
    in_target_row  = AT_CURSOR;
    in_target_col  = AT_CURSOR;
    in_colour      = 4'd0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    geo_cols       = COLUMNS_RST;
    geo_rows       = ROWS_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset geometry 80 x 30, scroll 1.
    set_idle(IDLE_BOTH);
    send_char("A", AT_CURSOR, AT_CURSOR, 4'd0);          // colour 0 drawn white
    send_char(8'hFF, 9'sd255, 9'sd255, 4'hF);           // far corner: scroll, wrap
    send_char(8'h00, AT_CURSOR, AT_CURSOR, 4'd1);
    send_char(CH_CR, 9'sd3, 9'sd3, 4'd2);                // ignored, cursor kept
    send_char(CH_ESC, AT_CURSOR, AT_CURSOR, 4'd2);       // ignored
    send_char(CH_NEWLINE, AT_CURSOR, AT_CURSOR, 4'd3);
    send_char("B", 9'sd0, 9'sd0, 4'hA);                  // explicit cell moves cursor
    send_char(CH_BACKSPACE, AT_CURSOR, AT_CURSOR, 4'd4);
    send_char(CH_BACKSPACE, AT_CURSOR, AT_CURSOR, 4'd4); // origin: stays at 0,0
    send_char("C", AT_CURSOR, 9'sd5, 4'd6);              // only one target given
    send_char("D", 9'sd7, AT_CURSOR, 4'd7);
    send_char(CH_TAB, 9'sd10, 9'sd10, 4'd3);             // tab ignores cell and colour
    send_char(CH_NEWLINE, AT_CURSOR, AT_CURSOR, 4'd9);   // no scroll, no command
    send_char(CH_BACKSPACE, 9'sd3, 9'sd0, 4'd1);         // wrap to end of row above
    send_char("E", 9'sd29, 9'sd78, 4'hC);
    send_char(CH_TAB, AT_CURSOR, AT_CURSOR, 4'd0);       // wraps and scrolls inside
    send_char(8'h7F, AT_CURSOR, AT_CURSOR, 4'h8);

    // Zero registers: wrap and scroll on every placement, scroll of 0 rows.
    set_geometry(0, 0, 0);
    send_char("F", AT_CURSOR, AT_CURSOR, 4'h2);
    send_char(CH_BACKSPACE, 9'sd5, 9'sd0, 4'h2);         // wrapped column is 0
    send_char(CH_NEWLINE, 9'sd255, 9'sd255, 4'h2);       // row holds at 255
    send_char("G", AT_CURSOR, AT_CURSOR, 4'h2);

    // Scroll larger than the row: the row floors at 0.
    set_geometry(2, 2, 200);
    send_char("H", 9'sd5, 9'sd0, 4'h5);
    send_char(CH_TAB, AT_CURSOR, AT_CURSOR, 4'h5);
    send_char(CH_BACKSPACE, 9'sd0, 9'sd0, 4'h5);
    send_char(8'h55, 9'sd170, 9'sd85, 4'h5);

    // Random phases over extreme, tiny, small, random and reset geometries.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: set_geometry(255, 255, 255);
        1: set_geometry(1, 1, 1);
        2: set_geometry(5, 3, 2);
        3: set_geometry($urandom_range(12, 2), $urandom_range(6, 1), $urandom_range(8, 1));
        4: set_geometry($urandom_range(255, 1), $urandom_range(255, 1),
                        $urandom_range(255, 1));
        default: begin
          set_geometry(COLUMNS_RST, ROWS_RST, SCROLL_RST);
          // a write to the unused index must leave every register alone
          write_reg(REG_SPARE, 8'($urandom));
        end
      endcase
      set_idle(idle_mode_t'(phase % 4));
      repeat (ITEMS_PER_PHASE) send_random_char();
    end

    drain_block();
    if (error_count == 0 && pending_count == 0) begin
      $display("** text_console_cursor_engine_unit: PASSED **");
    end else begin
      $display("** text_console_cursor_engine_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("** text_console_cursor_engine_unit: FAILED **");
    $finish;
  end

endmodule

### text_console_cursor_engine_unit.f
src/tcce_pkg.sv
src/tcce_ctrl.sv
src/tcce_datapath.sv
src/text_console_cursor_engine_unit.sv
tb/tcce_cmd_checker.sv
tb/text_console_cursor_engine_unit_tb.sv
